>>> sv/qvdp_pkg.sv
// Shared types and constants for the quadratic value palindrome test block.
package qvdp_pkg;

  localparam int unsigned IndexW    = 63;
  localparam int unsigned ValW      = 128;
  localparam int unsigned InDataW   = 64;
  localparam int unsigned OutDataW  = 192;
  localparam int unsigned MulW      = 32;
  localparam int unsigned LimbW     = 16;
  localparam int unsigned NumLimbs  = ValW / LimbW;
  localparam int unsigned LimbCntW  = $clog2(NumLimbs);
  localparam int unsigned DigitW    = 4;
  localparam int unsigned DivXW     = DigitW + LimbW;
  localparam int unsigned RecipShift = 23;
  localparam logic [DivXW-1:0] Recip10 = DivXW'(838861);
  localparam int unsigned FiltW     = 4;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam logic RegLeadDigit     = 1'b0;

  typedef struct packed {
    logic       div_mode;
    logic [1:0] sq_phase;
  } mul_ctl_t;

endpackage

>>> sv/qvdp_mul.sv
// Shared 32x32 multiplier with operand selection for squaring and divide-by-ten steps.
module qvdp_mul (
  input  qvdp_pkg::mul_ctl_t                     ctl_i,
  input  logic [qvdp_pkg::IndexW-1:0]            index_i,
  input  logic [qvdp_pkg::DivXW-1:0]             div_x_i,
  output logic [2*qvdp_pkg::MulW-1:0]            prod_o
);
  import qvdp_pkg::*;

  logic [MulW-1:0] lo_half;
  logic [MulW-1:0] hi_half;
  logic [MulW-1:0] op_a;
  logic [MulW-1:0] op_b;

  assign lo_half = index_i[MulW-1:0];
  assign hi_half = MulW'(index_i[IndexW-1:MulW]);

  always_comb begin
    if (ctl_i.div_mode) begin
      op_a = MulW'(div_x_i);
      op_b = MulW'(Recip10);
    end else begin
      unique case (ctl_i.sq_phase)
        2'd0: begin
          op_a = lo_half;
          op_b = lo_half;
        end
        2'd1: begin
          op_a = lo_half;
          op_b = hi_half;
        end
        default: begin
          op_a = hi_half;
          op_b = hi_half;
        end
      endcase
    end
  end

  assign prod_o = (2*MulW)'(op_a) * (2*MulW)'(op_b);

endmodule

>>> sv/qvdp_apb.sv
// Configuration register file behind an APB-style port.
module qvdp_apb (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel_i,
  input  logic                            penable_i,
  input  logic                            pwrite_i,
  input  logic [qvdp_pkg::CfgAddrW-1:0]   paddr_i,
  input  logic [qvdp_pkg::CfgDataW-1:0]   pwdata_i,
  output logic [qvdp_pkg::CfgDataW-1:0]   prdata_o,
  output logic                            pready_o,
  output logic [qvdp_pkg::FiltW-1:0]      lead_digit_o
);
  import qvdp_pkg::*;

  logic [FiltW-1:0] lead_digit_q;
  logic             hit;

  assign pready_o = 1'b1;
  assign hit      = (paddr_i[CfgAddrW-1] == RegLeadDigit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_digit_q <= '0;
    end else if (psel_i && penable_i && pwrite_i && pready_o && hit) begin
      lead_digit_q <= pwdata_i[FiltW-1:0];
    end
  end

  assign prdata_o     = hit ? CfgDataW'(lead_digit_q) : '0;
  assign lead_digit_o = lead_digit_q;

endmodule

>>> sv/quadratic_value_decimal_palindrome_test.sv
// Sequence: squaring phases, then one pass over the 16-bit limbs per decimal digit of p, then a finish step.
// An item with d digits (1..39) takes d digit passes before its result is shown.
// A new item is taken only in IDLE, after the last result is loaded; the shared 32x32 multiplier
// forms n^2 and then divides p by ten one 16-bit limb per cycle.
// Reset: asynchronous, active low; clears the sequencer, output valid and the filter.
module quadratic_value_decimal_palindrome_test #(
  parameter int unsigned MAX_DIGITS = 39
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // [62:0] index_n
  input  logic [qvdp_pkg::InDataW-1:0]      s_axis_tdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [0] is_palindrome, [63:1] index_echo, [126:64] value_high, [190:127] value_low
  output logic [qvdp_pkg::OutDataW-1:0]     m_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [qvdp_pkg::CfgAddrW-1:0]     paddr,
  input  logic [qvdp_pkg::CfgDataW-1:0]     pwdata,
  output logic [qvdp_pkg::CfgDataW-1:0]     prdata,
  output logic                              pready
);
  import qvdp_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_DIGITS + 1);
  localparam int unsigned RevW = (MAX_DIGITS * 3322) / 1000 + 2;
  localparam int unsigned CmpW = (RevW > ValW) ? RevW : ValW;

  typedef enum logic [1:0] {
    IDLE,
    SQUARE,
    DIVIDE,
    FINISH
  } state_e;

  state_e               state_q;
  logic [1:0]           phase_q;
  logic [LimbCntW-1:0]  limb_q;
  logic [CntW-1:0]      cnt_q;
  logic                 m_valid_q;

  logic [IndexW-1:0]    n_q;
  logic [ValW-1:0]      acc_q;
  logic [2*MulW-1:0]    prod_q;
  logic [ValW-1:0]      t_q;
  logic [DigitW-1:0]    rem_q;
  logic [RevW-1:0]      rev_q;
  logic [DigitW-1:0]    first_q;
  logic                 left_q;
  logic [OutDataW-1:0]  out_q;

  logic [FiltW-1:0]     lead_digit;
  mul_ctl_t             mul_ctl;
  logic [2*MulW-1:0]    mul_p;
  logic [DivXW-1:0]     div_x;
  logic [LimbW-1:0]     q_limb;
  logic [DivXW-1:0]     q_times10;
  logic [DivXW-1:0]     r_full;
  logic [DigitW-1:0]    digit;
  logic [ValW-1:0]      t_d;
  logic [ValW-1:0]      addend;
  logic [ValW-1:0]      acc_d;
  logic [RevW-1:0]      rev_d;
  logic [CntW-1:0]      cnt_d;
  logic                 last_limb;
  logic                 pass_done;
  logic                 in_fire;
  logic                 out_load;
  logic                 pal;

  qvdp_apb u_apb (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .prdata_o    (prdata),
    .pready_o    (pready),
    .lead_digit_o(lead_digit)
  );

  assign mul_ctl.div_mode = (state_q == DIVIDE);
  assign mul_ctl.sq_phase = phase_q;
  assign div_x            = {rem_q, t_q[ValW-1 -: LimbW]};

  qvdp_mul u_mul (
    .ctl_i  (mul_ctl),
    .index_i(n_q),
    .div_x_i(div_x),
    .prod_o (mul_p)
  );

  assign q_limb    = mul_p[RecipShift +: LimbW];
  assign q_times10 = DivXW'({q_limb, 3'b000}) + DivXW'({q_limb, 1'b0});
  assign r_full    = div_x - q_times10;
  assign digit     = r_full[DigitW-1:0];
  assign t_d       = {t_q[ValW-LimbW-1:0], q_limb};
  assign rev_d     = (rev_q << 3) + (rev_q << 1) + RevW'(digit);
  assign cnt_d     = cnt_q + CntW'(1);
  assign last_limb = (limb_q == LimbCntW'(NumLimbs - 1));
  assign pass_done = (t_d == '0) || (cnt_d == CntW'(MAX_DIGITS));

  always_comb begin
    unique case (phase_q)
      2'd1:    addend = ValW'(prod_q) << 1;
      2'd2:    addend = ValW'(prod_q) << (MulW + 2);
      2'd3:    addend = ValW'(prod_q) << (2*MulW + 1);
      default: addend = '0;
    endcase
  end
  assign acc_d = acc_q + addend;

  assign s_axis_tready = (state_q == IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == FINISH) && (!m_valid_q || m_axis_tready);

  assign pal = !left_q && (cnt_q != '0) &&
               ((lead_digit == '0) || (FiltW'(first_q) == lead_digit)) &&
               (CmpW'(rev_q) == CmpW'(acc_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= IDLE;
      phase_q   <= '0;
      limb_q    <= '0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        IDLE: begin
          if (in_fire) begin
            phase_q <= '0;
            state_q <= SQUARE;
          end
        end
        SQUARE: begin
          phase_q <= phase_q + 2'd1;
          if (phase_q == 2'd3) begin
            limb_q  <= '0;
            cnt_q   <= '0;
            state_q <= (acc_d == '0) ? FINISH : DIVIDE;
          end
        end
        DIVIDE: begin
          limb_q <= limb_q + LimbCntW'(1);
          if (last_limb) begin
            cnt_q <= cnt_d;
            if (pass_done) begin
              state_q <= FINISH;
            end
          end
        end
        FINISH: begin
          if (out_load) begin
            state_q <= IDLE;
          end
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    if (in_fire) begin
      n_q   <= s_axis_tdata[IndexW-1:0];
      acc_q <= ValW'({s_axis_tdata[IndexW-1:0], 1'b1});
    end
    if (state_q == SQUARE) begin
      acc_q <= acc_d;
      if (phase_q == 2'd3) begin
        t_q    <= acc_d;
        rem_q  <= '0;
        rev_q  <= '0;
        left_q <= 1'b0;
      end
    end
    if (state_q == DIVIDE) begin
      t_q   <= t_d;
      rem_q <= last_limb ? '0 : digit;
      if (last_limb) begin
        rev_q <= rev_d;
        if (cnt_q == '0) begin
          first_q <= digit;
        end
        left_q <= (t_d != '0);
      end
    end
    if (out_load) begin
      out_q <= {1'b0, acc_q[2*MulW-1:0], acc_q[ValW-2:2*MulW], n_q, pal};
    end
  end

  assign m_axis_tdata  = out_q;
  assign m_axis_tvalid = m_valid_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready)
    else $error("input accepted while an item is in progress");

  a_digit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_DIGITS))
    else $error("digit count beyond limit");

  a_rem_decimal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == DIVIDE) |-> (rem_q < DigitW'(10)))
    else $error("partial remainder not a decimal digit");

  a_pass_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == DIVIDE) && $past(state_q == SQUARE) |-> (limb_q == '0))
    else $error("digit pass did not start on the top limb");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking stream testbench for the quadratic value decimal palindrome test block.
module tb;
  import qvdp_pkg::*;

  localparam int unsigned MaxDigits   = 39;
  localparam int unsigned PhaseItems  = 205;
  localparam int unsigned HoldCycles  = 2000;
  localparam int unsigned DrainCycles = 400;
  localparam int unsigned SearchLimit = 30000;
  localparam logic [CfgAddrW-1:0] LeadDigitAddr = CfgAddrW'(4 * RegLeadDigit);

  typedef struct {
    logic              pal;
    logic [IndexW-1:0] idx;
    logic [62:0]       hi;
    logic [63:0]       lo;
  } verdict_t;

  class verdict_board;
    logic [FiltW-1:0] lead_filter;
    verdict_t         pending[$];
    int unsigned      failures;
    int unsigned      checked;
    int unsigned      pal_seen;

    function new();
      lead_filter = '0;
      failures    = 0;
      checked     = 0;
      pal_seen    = 0;
    endfunction

    function logic [ValW-1:0] curve_value(logic [IndexW-1:0] n);
      logic [ValW-1:0] w;
      w = ValW'(n);
      return ((w * w) << 1) + (w << 1) + ValW'(1);
    endfunction

    function bit reads_both_ways(logic [ValW-1:0] p);
      logic [3:0]      digit[MaxDigits];
      logic [ValW-1:0] t;
      int              cnt;
      t   = p;
      cnt = 0;
      while (t != 0 && cnt < MaxDigits) begin
        digit[cnt] = 4'(t % 10);
        t = t / 10;
        cnt++;
      end
      if (t != 0 || cnt == 0) return 1'b0;
      for (int i = 0; i < cnt / 2; i++) begin
        if (digit[i] != digit[cnt-1-i]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function verdict_t predict_verdict(logic [IndexW-1:0] n);
      verdict_t        v;
      logic [ValW-1:0] p;
      p     = curve_value(n);
      v.idx = n;
      v.hi  = p[126:64];
      v.lo  = p[63:0];
      v.pal = reads_both_ways(p) && (lead_filter == 0 || 4'(p % 10) == lead_filter);
      return v;
    endfunction

    function void flag(string what, logic [127:0] want, logic [127:0] got);
      failures++;
      if (failures <= 10) $display("mismatch %s: expected %0h, got %0h", what, want, got);
    endfunction

    function void note_index(logic [IndexW-1:0] n);
      pending.push_back(predict_verdict(n));
    endfunction

    function void check_result(logic [OutDataW-1:0] d);
      verdict_t w;
      checked++;
      if (pending.size() == 0) begin
        flag("unrequested result, index", '0, d[63:1]);
        return;
      end
      w = pending.pop_front();
      if (d[0] !== w.pal) flag("is_palindrome", w.pal, d[0]);
      if (d[63:1] !== w.idx) flag("index_echo", w.idx, d[63:1]);
      if (d[126:64] !== w.hi) flag("value_high", w.hi, d[126:64]);
      if (d[190:127] !== w.lo) flag("value_low", w.lo, d[190:127]);
      if (d[0] === 1'b1) pal_seen++;
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [CfgAddrW-1:0] paddr         = '0;
  logic [CfgDataW-1:0] pwdata        = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  verdict_board      board;
  logic [IndexW-1:0] pal_n[$];
  logic [IndexW-1:0] directed[$];
  bit                calm      = 1'b0;
  bit                hold_req  = 1'b0;
  int unsigned       hold_left = 0;
  int unsigned       sent      = 0;

  quadratic_value_decimal_palindrome_test u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 14);
    end
  end

  task automatic send_index(input logic [IndexW-1:0] n);
    if (!calm && $urandom_range(99) < 14) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tdata  <= {1'b0, n};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_index(n);
    sent++;
  endtask

  task automatic wait_drained();
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_filter(input logic [FiltW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LeadDigitAddr;
    pwdata  <= CfgDataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.lead_filter = value;
    @(posedge clk_i);
  endtask

  task automatic read_filter();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= LeadDigitAddr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== CfgDataW'(board.lead_filter)) begin
      board.flag("lead_digit_filter readback", board.lead_filter, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [IndexW-1:0] pick_index();
    int unsigned sel;
    logic [63:0] r;
    sel = $urandom_range(99);
    r   = {$urandom, $urandom};
    if (sel < 35) return r[62:0];
    if (sel < 55) return r[62:0] >> $urandom_range(62);
    if (sel < 75) return IndexW'($urandom_range(3000));
    return pal_n[$urandom_range(pal_n.size() - 1)];
  endfunction

  initial begin
    #40_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [FiltW-1:0] filters[] = '{4'd1, 4'd5, 4'd3, 4'd9, 4'd15, 4'd10, 4'd0, 4'd7};
    board = new();
    for (int n = 0; n <= SearchLimit; n++) begin
      if (board.reads_both_ways(board.curve_value(IndexW'(n)))) pal_n.push_back(IndexW'(n));
    end
    directed = '{63'd0, 63'd1, 63'd2, 63'd9, 63'd10, 63'd12, 63'd16,
                 {63{1'b1}}, {{62{1'b1}}, 1'b0}, 63'h4000_0000_0000_0000,
                 63'h0000_0000_FFFF_FFFF, 63'h0000_0001_0000_0000, 63'h0000_0000_8000_0000,
                 63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA,
                 63'd3037000499, 63'd3037000500};
    directed.push_back(pal_n[$]);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    read_filter();
    @(posedge clk_i);
    foreach (directed[i]) send_index(directed[i]);
    s_axis_tvalid <= 1'b0;

    foreach (filters[p]) begin
      wait_drained();
      write_filter(filters[p]);
      read_filter();
      @(posedge clk_i);
      calm = (p == 3);
      for (int i = 0; i < PhaseItems; i++) begin
        // stall the output long enough to back the block up
        if (p == 1 && i == 40) hold_req = 1'b1;
        send_index(pick_index());
      end
      s_axis_tvalid <= 1'b0;
    end
    calm = 1'b0;

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (board.pending.size() != 0) begin
      board.flag("results never delivered", board.pending.size(), '0);
    end
    $display("covered %0d requests over %0d lead-digit settings, %0d results checked",
             sent, filters.size() + 1, board.checked);
    $display("%0d palindrome verdicts seen, %0d palindromic small indexes in the mix",
             board.pal_seen, pal_n.size());
    if (board.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
